[sv/tdgsm_pkg.sv]
// Shared constants, codes and types of the table-driven guard state machine.
package tdgsm_pkg;

  localparam int MAX_TRANSITIONS = 16;
  localparam int NUM_STATES      = 16;
  localparam int NUM_EVENTS      = 16;
  localparam int ACTION_LIMIT    = 32;

  localparam int IDX_W    = $clog2(MAX_TRANSITIONS);
  localparam int CNT_W    = $clog2(MAX_TRANSITIONS + 1);
  localparam int ST_IDX_W = $clog2(NUM_STATES);
  localparam int STATE_W  = 5;
  localparam int EV_W     = 4;
  localparam int PARAM_W  = 16;
  localparam int NEXT_W   = 4;
  localparam int MASK_W   = 32;

  localparam logic [PARAM_W-1:0] PARAM_WILDCARD = 16'hFFFF;
  localparam logic [STATE_W-1:0] STATE_ANY      = STATE_W'(NUM_STATES);

  // configuration register index (byte address bit 2)
  localparam logic REG_INITIAL_STATE    = 1'b0;
  localparam logic REG_TRANSITION_COUNT = 1'b1;

  typedef enum logic [2:0] {
    KIND_INIT      = 3'd0,
    KIND_EVENT     = 3'd1,
    KIND_QUERY     = 3'd2,
    KIND_WR_TRANS  = 3'd3,
    KIND_WR_DENY   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD     = 2'd1,
    STATUS_NOMATCH = 2'd2
  } status_t;

  typedef struct packed {
    logic [STATE_W-1:0] src;
    logic [EV_W-1:0]    ev;
    logic [PARAM_W-1:0] param;
    logic [NEXT_W-1:0]  next;
  } trans_entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    trans_entry_t     entry;
  } trans_wr_t;

  typedef struct packed {
    logic                we;
    logic [ST_IDX_W-1:0] addr;
    logic [MASK_W-1:0]   mask;
  } deny_wr_t;

  typedef struct packed {
    logic              done;
    logic              hit;
    logic [NEXT_W-1:0] next;
  } scan_res_t;

  typedef struct packed {
    logic done;
    logic allowed;
  } guard_res_t;

endpackage

[sv/tdgsm_scan.sv]
// Transition table memory and the sequential first-match scan over it.
module tdgsm_scan (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tdgsm_pkg::CNT_W-1:0]     limit,
  input  logic [tdgsm_pkg::STATE_W-1:0]   present,
  input  logic [tdgsm_pkg::EV_W-1:0]      ev,
  input  logic [tdgsm_pkg::PARAM_W-1:0]   param,
  input  tdgsm_pkg::trans_wr_t            wr,
  output tdgsm_pkg::scan_res_t            res
);

  tdgsm_pkg::trans_entry_t mem [tdgsm_pkg::MAX_TRANSITIONS];
  tdgsm_pkg::trans_entry_t rd_q;

  logic                          busy_r,    busy_nxt;
  logic [tdgsm_pkg::CNT_W-1:0]   cnt_r,     cnt_nxt;
  logic [tdgsm_pkg::CNT_W-1:0]   lim_r;
  logic                          rd_vld_r,  rd_vld_nxt;
  logic                          rd_last_r, rd_last_nxt;
  logic                          done_r,    done_nxt;
  logic                          hit_r;
  logic [tdgsm_pkg::NEXT_W-1:0]  next_r;
  logic [tdgsm_pkg::EV_W-1:0]    ev_r;
  logic [tdgsm_pkg::PARAM_W-1:0] param_r;
  logic                          issue, match, finish;

  assign issue = busy_r && (cnt_r < lim_r);

  // entry read last cycle against the latched event
  assign match = rd_vld_r
              && (rd_q.src == present || rd_q.src == tdgsm_pkg::STATE_ANY)
              && (rd_q.ev == ev_r)
              && (rd_q.param == tdgsm_pkg::PARAM_WILDCARD || rd_q.param == param_r);
  assign finish = rd_vld_r && (match || rd_last_r);

  always_comb begin
    busy_nxt    = busy_r;
    cnt_nxt     = cnt_r;
    rd_vld_nxt  = issue && !finish;
    rd_last_nxt = (cnt_r == lim_r - tdgsm_pkg::CNT_W'(1));
    done_nxt    = finish;
    if (start) begin
      busy_nxt = (limit != '0);
      cnt_nxt  = '0;
      done_nxt = (limit == '0);
    end else begin
      if (finish) busy_nxt = 1'b0;
      if (issue)  cnt_nxt  = cnt_r + tdgsm_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      cnt_r     <= '0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      cnt_r     <= cnt_nxt;
      rd_vld_r  <= rd_vld_nxt;
      rd_last_r <= rd_last_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      lim_r   <= limit;
      ev_r    <= ev;
      param_r <= param;
    end
    if (done_nxt) begin
      hit_r  <= finish && match;
      next_r <= rd_q.next;
    end
  end

  // synchronous table memory, one read and one write per cycle
  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr] <= wr.entry;
    if (issue) rd_q <= mem[cnt_r[tdgsm_pkg::IDX_W-1:0]];
  end

  assign res.done = done_r;
  assign res.hit  = hit_r;
  assign res.next = next_r;

endmodule

[sv/tdgsm_guard.sv]
// Deny mask memory and the action permission check.
module tdgsm_guard (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          initialised,
  input  logic [tdgsm_pkg::STATE_W-1:0] present,
  input  logic [15:0]                   action,
  input  tdgsm_pkg::deny_wr_t           wr,
  output tdgsm_pkg::guard_res_t         res
);

  logic [tdgsm_pkg::MASK_W-1:0] mem [tdgsm_pkg::NUM_STATES];
  logic [tdgsm_pkg::MASK_W-1:0] rd_q;
  logic                         done_r;
  logic                         ok_r;
  logic [4:0]                   bit_r;
  logic                         ok;

  assign ok = initialised
           && (present < tdgsm_pkg::STATE_W'(tdgsm_pkg::NUM_STATES))
           && ({16'd0, action} < 32'(tdgsm_pkg::ACTION_LIMIT));

  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else        done_r <= start;
  end

  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr] <= wr.mask;
    if (start) begin
      rd_q  <= mem[present[tdgsm_pkg::ST_IDX_W-1:0]];
      ok_r  <= ok;
      bit_r <= action[4:0];
    end
  end

  assign res.done    = done_r;
  assign res.allowed = ok_r && !rd_q[bit_r];

endmodule

[sv/table_driven_guard_state_machine.sv]
// Top level of the table-driven guard state machine: control, registers, result stage.
//
// Usage
// - Input channel (in_valid/in_ready): one item per transfer, kind selects
//   init, event, action query, transition entry write or deny mask write.
// - Result channel (out_valid/out_ready): exactly one result per item, in
//   order: status, allowed and the state after the item (16 = not yet
//   initialised).
// - APB-style register port: initial_state at 0x0, transition_count at 0x4;
//   write only while the block is idle. pready is tied high.
// - Items are handled one at a time. Init, loads and unknown kinds go
//   from idle straight to the flush state; a query passes the query
//   state first (one deny memory read); a valid event scans the
//   transition memory one entry per cycle (the single read port's rate),
//   first match wins, over at most min(transition_count,16) entries.
// - in_ready rises again once the result is in the output register, so the
//   next item is taken while that result still waits for the receiver.
// - A stalled receiver holds the result; a finished item then waits in the
//   flush state until the output register frees up.
// - Reset: state reads 16 (not initialised), registers 0, no result
//   pending. Table and mask memories are not cleared; load before use.
module table_driven_guard_state_machine (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_event_code,
  input  logic [15:0] in_event_param,
  input  logic [15:0] in_action_num,
  input  logic [3:0]  in_entry_index,
  input  logic [4:0]  in_entry_state,
  input  logic [3:0]  in_entry_event,
  input  logic [15:0] in_entry_param,
  input  logic [3:0]  in_entry_next,
  input  logic [31:0] in_deny_mask,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_allowed,
  output logic [4:0]  out_current_state,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_QUERY,
    ST_FLUSH
  } ctrl_state_t;

  ctrl_state_t                    state_r, state_nxt;
  logic [tdgsm_pkg::STATE_W-1:0]  present_r, present_nxt;
  logic                           init_r, init_nxt;
  logic [3:0]                     init_state_r, init_state_nxt;
  logic [4:0]                     tcount_r, tcount_nxt;
  tdgsm_pkg::status_t             res_status_r, res_status_nxt;
  logic                           res_allowed_r, res_allowed_nxt;
  logic                           out_valid_r, out_valid_nxt;
  tdgsm_pkg::status_t             out_status_r, out_status_nxt;
  logic                           out_allowed_r, out_allowed_nxt;
  logic [tdgsm_pkg::STATE_W-1:0]  out_state_r, out_state_nxt;

  logic                           accept, cfg_wr;
  logic                           scan_start, guard_start;
  logic [tdgsm_pkg::CNT_W-1:0]    scan_limit;
  tdgsm_pkg::trans_wr_t           trans_wr;
  tdgsm_pkg::deny_wr_t            deny_wr;
  tdgsm_pkg::scan_res_t           scan_res;
  tdgsm_pkg::guard_res_t          guard_res;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  // register port: write on the access phase, reads are combinational
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == tdgsm_pkg::REG_TRANSITION_COUNT) ? {27'd0, tcount_r}
                                                               : {28'd0, init_state_r};

  // entries beyond the table never take part
  assign scan_limit = (tcount_r > tdgsm_pkg::CNT_W'(tdgsm_pkg::MAX_TRANSITIONS))
                    ? tdgsm_pkg::CNT_W'(tdgsm_pkg::MAX_TRANSITIONS)
                    : tdgsm_pkg::CNT_W'(tcount_r);

  // table writes straight from the accepted item
  always_comb begin
    trans_wr.we          = accept && (in_kind == tdgsm_pkg::KIND_WR_TRANS)
                        && ({1'b0, in_entry_index} < 5'(tdgsm_pkg::MAX_TRANSITIONS));
    trans_wr.addr        = in_entry_index[tdgsm_pkg::IDX_W-1:0];
    trans_wr.entry.src   = in_entry_state;
    trans_wr.entry.ev    = in_entry_event;
    trans_wr.entry.param = in_entry_param;
    trans_wr.entry.next  = in_entry_next;
    deny_wr.we   = accept && (in_kind == tdgsm_pkg::KIND_WR_DENY)
                && (in_entry_state < tdgsm_pkg::STATE_W'(tdgsm_pkg::NUM_STATES));
    deny_wr.addr = in_entry_state[tdgsm_pkg::ST_IDX_W-1:0];
    deny_wr.mask = in_deny_mask;
  end

  tdgsm_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .limit   (scan_limit),
    .present (present_r),
    .ev      (in_event_code[tdgsm_pkg::EV_W-1:0]),
    .param   (in_event_param),
    .wr      (trans_wr),
    .res     (scan_res)
  );

  tdgsm_guard u_guard (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (guard_start),
    .initialised (init_r),
    .present     (present_r),
    .action      (in_action_num),
    .wr          (deny_wr),
    .res         (guard_res)
  );

  always_comb begin
    state_nxt       = state_r;
    present_nxt     = present_r;
    init_nxt        = init_r;
    init_state_nxt  = init_state_r;
    tcount_nxt      = tcount_r;
    res_status_nxt  = res_status_r;
    res_allowed_nxt = res_allowed_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_allowed_nxt = out_allowed_r;
    out_state_nxt   = out_state_r;
    scan_start      = 1'b0;
    guard_start     = 1'b0;

    if (cfg_wr) begin
      if (paddr[2] == tdgsm_pkg::REG_TRANSITION_COUNT) tcount_nxt = pwdata[4:0];
      else                                               init_state_nxt = pwdata[3:0];
    end

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_status_nxt  = tdgsm_pkg::STATUS_OK;
          res_allowed_nxt = 1'b0;
          state_nxt       = ST_FLUSH;
          case (tdgsm_pkg::kind_t'(in_kind))
            tdgsm_pkg::KIND_INIT: begin
              present_nxt = {1'b0, init_state_r};
              init_nxt    = 1'b1;
            end
            tdgsm_pkg::KIND_EVENT: begin
              if (!init_r || ({1'b0, in_event_code} >= 9'(tdgsm_pkg::NUM_EVENTS))) begin
                res_status_nxt = tdgsm_pkg::STATUS_BAD;
              end else begin
                scan_start = 1'b1;
                state_nxt  = ST_SCAN;
              end
            end
            tdgsm_pkg::KIND_QUERY: begin
              guard_start = 1'b1;
              state_nxt   = ST_QUERY;
            end
            tdgsm_pkg::KIND_WR_TRANS, tdgsm_pkg::KIND_WR_DENY: begin
              res_status_nxt = tdgsm_pkg::STATUS_OK;
            end
            default: res_status_nxt = tdgsm_pkg::STATUS_BAD;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.hit) begin
            present_nxt    = {1'b0, scan_res.next};
            res_status_nxt = tdgsm_pkg::STATUS_OK;
          end else begin
            res_status_nxt = tdgsm_pkg::STATUS_NOMATCH;
          end
          state_nxt = ST_FLUSH;
        end
      end
      ST_QUERY: begin
        if (guard_res.done) begin
          res_allowed_nxt = guard_res.allowed;
          res_status_nxt  = tdgsm_pkg::STATUS_OK;
          state_nxt       = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // wait for a free output register
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_allowed_nxt = res_allowed_r;
          out_state_nxt   = present_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      present_r    <= tdgsm_pkg::STATE_ANY;
      init_r       <= 1'b0;
      init_state_r <= '0;
      tcount_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      present_r    <= present_nxt;
      init_r       <= init_nxt;
      init_state_r <= init_state_nxt;
      tcount_r     <= tcount_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    res_status_r  <= res_status_nxt;
    res_allowed_r <= res_allowed_nxt;
    out_status_r  <= out_status_nxt;
    out_allowed_r <= out_allowed_nxt;
    out_state_r   <= out_state_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_allowed       = out_allowed_r;
  assign out_current_state = out_state_r;

endmodule

[sv/tdgsm_checker.sv]
// Port-level assertions for the guard state machine, bound to the top level.
module tdgsm_props (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic       out_allowed,
  input logic [4:0] out_current_state
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(out_status)
                                 && $stable(out_allowed) && $stable(out_current_state))
    else $error("stalled result changed");

  a_allowed_ok: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_allowed |-> out_status == tdgsm_pkg::STATUS_OK
                                   && out_current_state < 5'(tdgsm_pkg::NUM_STATES))
    else $error("allowed without a valid state");

  a_uninit_no_match: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_current_state == tdgsm_pkg::STATE_ANY
        |-> out_status != tdgsm_pkg::STATUS_NOMATCH && !out_allowed)
    else $error("table used before init");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

endmodule

bind table_driven_guard_state_machine tdgsm_props u_tdgsm_props (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_allowed       (out_allowed),
  .out_current_state (out_current_state)
);
